// ===== hdl/lse_pkg.sv =====
// Shared types and constants for the LIFO stack engine.
// Command and status codes, sequencer states, default depth.
// No dependencies.
package lse_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_REVERSE = 3'd3,
        CMD_SORT    = 3'd4,
        CMD_SLICE   = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_BADSLICE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_EMIT,
        S_REV_RD_I,
        S_REV_RD_J,
        S_REV_WR_I,
        S_REV_WR_J,
        S_SORT_SCAN,
        S_SORT_DRAIN,
        S_SORT_WR_MIN,
        S_SORT_WR_I,
        S_SLICE_RD,
        S_SLICE_EMIT
    } state_t;

endpackage

// ===== hdl/lifo_stack_engine_unit.sv =====
// LIFO stack engine: one-port synchronous store plus a command sequencer.
// Push and error results go through S_EMIT into the output register; pop/peek
// first read in S_RD_WAIT. Reverse swaps word pairs, sort selects each minimum,
// slice reads and emits each word; the input stalls until idle (one memory port).
// Reset clears the count and the sequencer; stored words stay undefined,
// no clearing pass is run, and in_stall is low from reset as the sequencer idles.
module lifo_stack_engine_unit #(
    parameter int  DEPTH = lse_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lse_pkg::CMD_W-1:0]           cmd,
    input  logic signed [lse_pkg::WORD_W-1:0]   value,
    input  logic [CNT_W-1:0]                    slice_start,
    input  logic [CNT_W-1:0]                    slice_end,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lse_pkg::WORD_W-1:0]   word,
    output logic [lse_pkg::STAT_W-1:0]          status,
    output logic [CNT_W-1:0]                    count,
    output logic                                last
);
    import lse_pkg::*;

    logic [WORD_W-1:0] mem_array [DEPTH];

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [IDX_W-1:0]          i_reg, i_next;
    logic [IDX_W-1:0]          j_reg, j_next;
    logic [CNT_W-1:0]          end_reg, end_next;
    logic [IDX_W-1:0]          ridx_reg, ridx_next;
    logic                      rvalid_reg, rvalid_next;
    logic signed [WORD_W-1:0]  min_reg, min_next;
    logic [IDX_W-1:0]          minidx_reg, minidx_next;
    logic signed [WORD_W-1:0]  tmp_reg, tmp_next;
    status_t                   res_status_reg, res_status_next;
    logic                      res_rd_reg, res_rd_next;
    logic signed [WORD_W-1:0]  rd_data_reg;

    logic                      out_valid_reg;
    logic signed [WORD_W-1:0]  word_reg;
    status_t                   status_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      last_reg;

    logic                      mem_rd_en;
    logic [IDX_W-1:0]          mem_rd_addr;
    logic                      mem_wr_en;
    logic [IDX_W-1:0]          mem_wr_addr;
    logic [WORD_W-1:0]         mem_wr_data;

    logic                      ld;
    logic signed [WORD_W-1:0]  ld_word;
    status_t                   ld_status;
    logic                      ld_last;

    logic                      accept;
    logic                      out_free;
    logic [CNT_W-1:0]          cnt_m1;
    logic [IDX_W-1:0]          top_idx;
    logic                      full;
    logic                      empty;
    logic                      slice_ok;
    logic                      slice_last;
    logic                      rev_more;
    logic                      sort_more;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign cnt_m1     = cnt_reg - CNT_W'(1);
    assign top_idx    = cnt_m1[IDX_W-1:0];
    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign empty      = (cnt_reg == '0);
    assign slice_ok   = (slice_start < slice_end) && (slice_end <= cnt_reg);
    assign slice_last = ((CNT_W'(i_reg) + CNT_W'(1)) == end_reg);
    assign rev_more   = (((IDX_W+1)'(i_reg) + (IDX_W+1)'(1)) <
                         ((IDX_W+1)'(j_reg) - (IDX_W+1)'(1)));
    assign sort_more  = (((IDX_W+1)'(i_reg) + (IDX_W+1)'(1)) < (IDX_W+1)'(top_idx));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (cmd) inside
                        CMD_POP, CMD_PEEK: state_next = empty ? S_EMIT : S_RD_WAIT;
                        CMD_REVERSE:       state_next = (cnt_reg > CNT_W'(1)) ? S_REV_RD_I : S_EMIT;
                        CMD_SORT:          state_next = (cnt_reg > CNT_W'(1)) ? S_SORT_SCAN : S_EMIT;
                        CMD_SLICE:         state_next = slice_ok ? S_SLICE_RD : S_EMIT;
                        default:           state_next = S_EMIT;
                    endcase
                end
            end
            S_RD_WAIT:     state_next = S_EMIT;
            S_EMIT:        state_next = out_free ? S_IDLE : S_EMIT;
            S_REV_RD_I:    state_next = S_REV_RD_J;
            S_REV_RD_J:    state_next = S_REV_WR_I;
            S_REV_WR_I:    state_next = S_REV_WR_J;
            S_REV_WR_J:    state_next = rev_more ? S_REV_RD_I : S_EMIT;
            S_SORT_SCAN:   state_next = (j_reg == top_idx) ? S_SORT_DRAIN : S_SORT_SCAN;
            S_SORT_DRAIN:  state_next = S_SORT_WR_MIN;
            S_SORT_WR_MIN: state_next = S_SORT_WR_I;
            S_SORT_WR_I:   state_next = sort_more ? S_SORT_SCAN : S_EMIT;
            S_SLICE_RD:    state_next = S_SLICE_EMIT;
            S_SLICE_EMIT:
            begin
                if (out_free)
                begin
                    state_next = slice_last ? S_IDLE : S_SLICE_RD;
                end
            end
            default:       state_next = S_IDLE;
        endcase
    end

    // Datapath controls and next values
    always_comb
    begin
        cnt_next        = cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        end_next        = end_reg;
        ridx_next       = ridx_reg;
        rvalid_next     = 1'b0;
        min_next        = min_reg;
        minidx_next     = minidx_reg;
        tmp_next        = tmp_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = i_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = i_reg;
        mem_wr_data     = '0;
        ld              = 1'b0;
        ld_word         = '0;
        ld_status       = STAT_OK;
        ld_last         = 1'b1;

        // fold the word returned by the scan into the running minimum
        if (rvalid_reg)
        begin
            if (ridx_reg == i_reg)
            begin
                min_next    = rd_data_reg;
                minidx_next = i_reg;
                tmp_next    = rd_data_reg;
            end
            else if (rd_data_reg < min_reg)
            begin
                min_next    = rd_data_reg;
                minidx_next = ridx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = STAT_OK;
                    res_rd_next     = 1'b0;
                    unique case (cmd) inside
                        CMD_PUSH:
                        begin
                            if (full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = cnt_reg[IDX_W-1:0];
                                mem_wr_data = value;
                                cnt_next    = cnt_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP, CMD_PEEK:
                        begin
                            if (empty)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = top_idx;
                                res_rd_next = 1'b1;
                                if (cmd == CMD_POP)
                                begin
                                    cnt_next = cnt_m1;
                                end
                            end
                        end
                        CMD_REVERSE:
                        begin
                            i_next = '0;
                            j_next = top_idx;
                        end
                        CMD_SORT:
                        begin
                            i_next = '0;
                            j_next = '0;
                        end
                        CMD_SLICE:
                        begin
                            if (slice_ok)
                            begin
                                i_next   = slice_start[IDX_W-1:0];
                                end_next = slice_end;
                            end
                            else
                            begin
                                res_status_next = STAT_BADSLICE;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ld        = 1'b1;
                    ld_word   = res_rd_reg ? rd_data_reg : '0;
                    ld_status = res_status_reg;
                end
            end
            S_REV_RD_I:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = i_reg;
            end
            S_REV_RD_J:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = j_reg;
                tmp_next    = rd_data_reg;
            end
            S_REV_WR_I:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = i_reg;
                mem_wr_data = rd_data_reg;
            end
            S_REV_WR_J:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = j_reg;
                mem_wr_data = tmp_reg;
                i_next      = i_reg + IDX_W'(1);
                j_next      = j_reg - IDX_W'(1);
            end
            S_SORT_SCAN:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = j_reg;
                ridx_next   = j_reg;
                rvalid_next = 1'b1;
                j_next      = j_reg + IDX_W'(1);
            end
            S_SORT_WR_MIN:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = i_reg;
                mem_wr_data = min_reg;
            end
            S_SORT_WR_I:
            begin
                // old word at i goes where the minimum was found
                mem_wr_en   = 1'b1;
                mem_wr_addr = minidx_reg;
                mem_wr_data = tmp_reg;
                i_next      = i_reg + IDX_W'(1);
                j_next      = i_reg + IDX_W'(1);
            end
            S_SLICE_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = i_reg;
            end
            S_SLICE_EMIT:
            begin
                if (out_free)
                begin
                    ld      = 1'b1;
                    ld_word = rd_data_reg;
                    ld_last = slice_last;
                    i_next  = i_reg + IDX_W'(1);
                end
            end
            default:
            begin
                rvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem_array[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            rd_data_reg <= mem_array[mem_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= ld || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        end_reg        <= end_next;
        ridx_reg       <= ridx_next;
        min_reg        <= min_next;
        minidx_reg     <= minidx_next;
        tmp_reg        <= tmp_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        if (ld)
        begin
            word_reg   <= ld_word;
            status_reg <= ld_status;
            count_reg  <= cnt_reg;
            last_reg   <= ld_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign word      = word_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign last      = last_reg;

    // every accepted beat moves the sequencer out of idle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after accepting a command");

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("stack count exceeds depth");

    // count moves only at the accept edge
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(cnt_reg))
        else $error("stack count changed without an accepted command");

    assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> (state_reg == S_SORT_SCAN || state_reg == S_SORT_DRAIN))
        else $error("scan read returned outside the sort scan");

    // a result is loaded only when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !ld)
        else $error("result loaded over a stalled beat");

endmodule

// ===== verif/tb_lifo_stack_engine_unit.sv =====
`timescale 1ns / 1ps
// Testbench for lifo_stack_engine_unit: directed and random command streams, checked
// beat by beat against an in-bench stack model. Depends on lse_pkg and the unit itself.
module tb_lifo_stack_engine_unit;
    import lse_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
    localparam int IDLE_LIMIT  = 20000;
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [WORD_W-1:0] word;
        status_t                  status;
        logic [CNT_BITS-1:0]      count;
        logic                     last;
    } stack_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [CMD_W-1:0]           cmd = '0;
    logic signed [WORD_W-1:0]   value = '0;
    logic [CNT_BITS-1:0]        slice_start = '0;
    logic [CNT_BITS-1:0]        slice_end = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [WORD_W-1:0]   word;
    logic [STAT_W-1:0]          status;
    logic [CNT_BITS-1:0]        count;
    logic                       last;

    // Stack model and expected result beats
    logic signed [WORD_W-1:0]   stack_mem [STACK_DEPTH];
    int                         stack_fill = 0;
    stack_result_t              pending_results [$];

    int gap_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int cmds_issued = 0;
    int beats_checked = 0;
    int peak_fill = 0;
    int n_underflow = 0;
    int n_overflow = 0;
    int n_badslice = 0;

    lifo_stack_engine_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .value       (value),
        .slice_start (slice_start),
        .slice_end   (slice_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .word        (word),
        .status      (status),
        .count       (count),
        .last        (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void expect_beat(logic signed [WORD_W-1:0] w, status_t st, logic lst);
        stack_result_t r;
        r.word   = w;
        r.status = st;
        r.count  = CNT_BITS'(stack_fill);
        r.last   = lst;
        pending_results.push_back(r);
    endfunction

    // Apply one accepted command to the model and queue the beats it should produce
    task automatic predict_command(input logic [CMD_W-1:0] op, input logic signed [WORD_W-1:0] v,
                                   input logic [CNT_BITS-1:0] s, input logic [CNT_BITS-1:0] e);
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] tmp;
        int i;
        int j;
        cmds_issued++;
        case (op)
            CMD_PUSH:
            begin
                if (stack_fill >= STACK_DEPTH)
                begin
                    n_overflow++;
                    expect_beat(0, STAT_FULL, 1'b1);
                end
                else
                begin
                    stack_mem[stack_fill] = v;
                    stack_fill++;
                    if (stack_fill > peak_fill)
                        peak_fill = stack_fill;
                    expect_beat(0, STAT_OK, 1'b1);
                end
            end
            CMD_POP, CMD_PEEK:
            begin
                if (stack_fill == 0)
                begin
                    n_underflow++;
                    expect_beat(0, STAT_EMPTY, 1'b1);
                end
                else
                begin
                    key = stack_mem[stack_fill - 1];
                    if (op == CMD_POP)
                        stack_fill--;
                    expect_beat(key, STAT_OK, 1'b1);
                end
            end
            CMD_REVERSE:
            begin
                for (i = 0; i < stack_fill / 2; i++)
                begin
                    tmp = stack_mem[i];
                    stack_mem[i] = stack_mem[stack_fill - 1 - i];
                    stack_mem[stack_fill - 1 - i] = tmp;
                end
                expect_beat(0, STAT_OK, 1'b1);
            end
            CMD_SORT:
            begin
                // insertion sort, signed ascending from the bottom
                for (i = 1; i < stack_fill; i++)
                begin
                    key = stack_mem[i];
                    j = i - 1;
                    while (j >= 0 && stack_mem[j] > key)
                    begin
                        stack_mem[j + 1] = stack_mem[j];
                        j--;
                    end
                    stack_mem[j + 1] = key;
                end
                expect_beat(0, STAT_OK, 1'b1);
            end
            CMD_SLICE:
            begin
                if (s >= e || e > stack_fill)
                begin
                    n_badslice++;
                    expect_beat(0, STAT_BADSLICE, 1'b1);
                end
                else
                begin
                    for (i = s; i < e; i++)
                        expect_beat(stack_mem[i], STAT_OK, i == e - 1);
                end
            end
            default:
                expect_beat(0, STAT_OK, 1'b1);
        endcase
    endtask

    // Drive one command beat; valid stays high afterwards unless the next call idles first
    task automatic issue_command(input logic [CMD_W-1:0] op, input logic signed [WORD_W-1:0] v,
                                 input logic [CNT_BITS-1:0] s, input logic [CNT_BITS-1:0] e);
        int gap;
        gap = 0;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd         <= op;
        value       <= v;
        slice_start <= s;
        slice_end   <= e;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_command(op, v, s, e);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return WORD_W'($urandom_range(0, 15)) - 32'sd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue_slice_random();
        logic [CNT_BITS-1:0] s;
        logic [CNT_BITS-1:0] e;
        if (stack_fill > 0 && $urandom_range(0, 99) < 80)
        begin
            s = CNT_BITS'($urandom_range(0, stack_fill - 1));
            e = CNT_BITS'($urandom_range(s + 1, stack_fill));
        end
        else
        begin
            s = CNT_BITS'($urandom_range(0, 127));
            e = CNT_BITS'($urandom_range(0, 127));
        end
        issue_command(CMD_SLICE, $urandom, s, e);
    endtask

    task automatic test_empty_stack();
        issue_command(CMD_POP, $urandom, 0, 0);
        issue_command(CMD_PEEK, $urandom, 0, 0);
        issue_command(CMD_REVERSE, $urandom, 0, 0);
        issue_command(CMD_SORT, $urandom, 0, 0);
        issue_command(CMD_SLICE, $urandom, 0, 0);
        issue_command(CMD_SPARE_LO, $urandom, 0, 0);
        issue_command(CMD_SPARE_HI, $urandom, 0, 0);
    endtask

    task automatic test_push_peek_extremes();
        issue_command(CMD_PUSH, 32'h7FFF_FFFF, 0, 0);
        issue_command(CMD_REVERSE, 0, 0, 0);
        issue_command(CMD_SORT, 0, 0, 0);
        issue_command(CMD_PUSH, 32'h8000_0000, 0, 0);
        issue_command(CMD_PUSH, 32'h0000_0000, 0, 0);
        issue_command(CMD_PUSH, 32'hFFFF_FFFF, 0, 0);
        issue_command(CMD_PUSH, 32'h0000_0001, 0, 0);
        issue_command(CMD_PEEK, 0, 0, 0);
        issue_command(CMD_REVERSE, 0, 0, 0);
    endtask

    task automatic test_slice_bounds();
        issue_command(CMD_SLICE, 0, 0, 5);
        issue_command(CMD_SLICE, 0, 2, 3);
        issue_command(CMD_SLICE, 0, 3, 3);
        issue_command(CMD_SLICE, 0, 4, 2);
        issue_command(CMD_SLICE, 0, 0, 6);
        issue_command(CMD_SLICE, 0, 127, 127);
        issue_command(CMD_SLICE, 0, 64, 127);
    endtask

    task automatic test_reorder();
        issue_command(CMD_SORT, 0, 0, 0);
        issue_command(CMD_SLICE, 0, 0, 5);
        issue_command(CMD_POP, 0, 0, 0);
        issue_command(CMD_POP, 0, 0, 0);
    endtask

    task automatic test_random_mix(input int n);
        int k;
        int r;
        for (k = 0; k < n; k++)
        begin
            // switch between idle-heavy and back-to-back stretches
            if (k % 30 == 0)
            begin
                gap_pct   = $urandom_range(0, 1) ? 25 : 0;
                stall_pct = $urandom_range(0, 1) ? 25 : 0;
            end
            r = $urandom_range(0, 99);
            if (r < 40)
                issue_command(CMD_PUSH, pick_word(),
                              CNT_BITS'($urandom), CNT_BITS'($urandom));
            else if (r < 58)
                issue_command(CMD_POP, $urandom, CNT_BITS'($urandom), CNT_BITS'($urandom));
            else if (r < 66)
                issue_command(CMD_PEEK, $urandom, CNT_BITS'($urandom), CNT_BITS'($urandom));
            else if (r < 72)
                issue_command(CMD_REVERSE, $urandom,
                              CNT_BITS'($urandom), CNT_BITS'($urandom));
            else if (r < 78)
                issue_command(CMD_SORT, $urandom, CNT_BITS'($urandom), CNT_BITS'($urandom));
            else if (r < 96)
                issue_slice_random();
            else
                issue_command($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO,
                              $urandom, CNT_BITS'($urandom), CNT_BITS'($urandom));
        end
    endtask

    task automatic test_full_stack();
        gap_pct   = 15;
        stall_pct = 15;
        while (stack_fill < STACK_DEPTH)
            issue_command(CMD_PUSH, pick_word(), 0, 0);
        issue_command(CMD_PUSH, $urandom, 0, 0);
        issue_command(CMD_PUSH, $urandom, 0, 0);
        issue_command(CMD_PEEK, 0, 0, 0);
        issue_command(CMD_SLICE, 0, 0, 64);
        issue_command(CMD_REVERSE, 0, 0, 0);
        issue_command(CMD_SLICE, 0, 0, 64);
        issue_command(CMD_SORT, 0, 0, 0);
        issue_command(CMD_SLICE, 0, 0, 64);
        issue_command(CMD_SLICE, 0, 63, 64);
        issue_command(CMD_SLICE, 0, 0, 65);
        issue_command(CMD_SLICE, 0, 64, 64);
        issue_command(CMD_SPARE_LO, 0, 0, 0);
        while (stack_fill > 0)
            issue_command(CMD_POP, 0, 0, 0);
        issue_command(CMD_POP, 0, 0, 0);
        issue_command(CMD_PEEK, 0, 0, 0);
    endtask

    task automatic test_back_to_back(input int n);
        int k;
        int r;
        gap_pct   = 0;
        stall_pct = 0;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                issue_command(CMD_PUSH, pick_word(), 0, 0);
            else if (r < 7)
                issue_command(CMD_POP, 0, 0, 0);
            else if (r < 8)
                issue_command(CMD_PEEK, 0, 0, 0);
            else
                issue_slice_random();
        end
    endtask

    // Sink side: random stall bursts
    int sink_left = 0;
    always @(posedge clk)
    begin
        if (stall_pct == 0)
        begin
            sink_left = 0;
            out_stall <= 1'b0;
        end
        else if (sink_left > 0)
        begin
            sink_left = sink_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            sink_left = $urandom_range(1, 7) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge clk)
    begin
        stack_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_checked++;
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected beat: word=%0d status=%0d count=%0d last=%0b",
                             word, status, count, last);
                mismatches++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (word !== exp_r.word || status !== exp_r.status ||
                    count !== exp_r.count || last !== exp_r.last)
                begin
                    if (mismatches < 10)
                    begin
                        $display("beat %0d: expected word=%0d status=%0d count=%0d last=%0b",
                                 beats_checked, exp_r.word, exp_r.status, exp_r.count,
                                 exp_r.last);
                        $display("beat %0d: got      word=%0d status=%0d count=%0d last=%0b",
                                 beats_checked, word, status, count, last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_stack();
        test_push_peek_extremes();
        test_slice_bounds();
        test_reorder();
        test_random_mix(170);
        test_full_stack();
        test_back_to_back(36);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d commands and %0d result beats, peak depth %0d of %0d",
                 cmds_issued, beats_checked, peak_fill, STACK_DEPTH);
        $display("error statuses: %0d underflow, %0d overflow, %0d bad slice; %0d mismatches",
                 n_underflow, n_overflow, n_badslice, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
